FILE: sv/gqsr_pkg.sv
// ----------------------------------------------------------------------------
// gqsr_pkg: shared types, constants and mode tables
// Field widths, transaction codes, stage structs and the per-mode shift and
// pixel decode functions of the playfield shift back end.
// ----------------------------------------------------------------------------
package gqsr_pkg;

	// default geometry
	localparam int QueueSlots = 16;
	localparam int LineBytes  = 48;

	// field widths
	localparam int ModeW   = 4;
	localparam int ByteW   = 8;
	localparam int PhaseW  = 6;
	localparam int DelayW  = 4;
	localparam int BitsW   = 2;
	localparam int ValueW  = 3;
	localparam int CtrlW   = 3;
	localparam int RingW   = 4;

	// line buffer byte read for an index beyond the store
	localparam logic [ByteW-1:0] LineMissByte = 8'hff;

	// char_control bit positions
	localparam int CtrlBlankInv = 0;
	localparam int CtrlInvert   = 1;

	// display modes with special handling
	localparam logic [ModeW-1:0] ModeChar2 = 4'd2;
	localparam logic [ModeW-1:0] ModeChar3 = 4'd3;
	localparam logic [ModeW-1:0] ModeChar4 = 4'd4;
	localparam logic [ModeW-1:0] ModeChar5 = 4'd5;
	localparam logic [ModeW-1:0] ModeChar6 = 4'd6;
	localparam logic [ModeW-1:0] ModeChar7 = 4'd7;
	localparam logic [ModeW-1:0] ModeMap8  = 4'd8;
	localparam logic [ModeW-1:0] ModeMap9  = 4'd9;
	localparam logic [ModeW-1:0] ModeMap10 = 4'd10;
	localparam logic [ModeW-1:0] ModeMap13 = 4'd13;
	localparam logic [ModeW-1:0] ModeMap14 = 4'd14;
	localparam logic [ModeW-1:0] ModeMap15 = 4'd15;

	// ring masks
	localparam logic [RingW-1:0] RingAll  = 4'h0f;
	localparam logic [RingW-1:0] RingHalf = 4'h05;
	localparam logic [RingW-1:0] RingOne  = 4'h01;

	typedef enum logic [1:0] {
		FUNC_TICK       = 2'd0,
		FUNC_SCHED_GFX  = 2'd1,
		FUNC_SCHED_LINE = 2'd2,
		FUNC_LINE_WR    = 2'd3
	} func_t;

	typedef struct packed {
		logic [RingW-1:0] mask;
		logic             two;
	} shift_cfg_t;

	// slot memory write request
	typedef struct packed {
		logic              data_we;
		logic              name_we;
		logic              phase_we;
		logic [ByteW-1:0]  data;
		logic [ByteW-1:0]  name;
		logic [PhaseW-1:0] phase;
	} slot_wr_t;

	// slot memory read data
	typedef struct packed {
		logic [ByteW-1:0]  data;
		logic [ByteW-1:0]  name;
		logic [PhaseW-1:0] phase;
	} slot_rd_t;

	// work handed to the shift stage
	typedef struct packed {
		logic             fire;
		logic             early;
		logic             load;
		logic             from_line;
		logic [ModeW-1:0] mode;
		logic [ByteW-1:0] data;
		logic [ByteW-1:0] name;
	} tick_op_t;

	// result of one transaction
	typedef struct packed {
		logic [ByteW-1:0]  name;
		logic [ValueW-1:0] value;
		logic [BitsW-1:0]  bits;
	} pixel_t;

	// ring mask and shift width per mode
	function automatic shift_cfg_t mode_shift_cfg(input logic [ModeW-1:0] mode);
		shift_cfg_t c;
		c.mask = RingAll;
		c.two  = 1'b0;
		case (mode) inside
			ModeChar2, ModeChar3, ModeChar4, ModeChar5,
			ModeMap13, ModeMap14, ModeMap15: begin
				c.two = 1'b1;
			end
			ModeMap8: begin
				c.mask = RingOne;
				c.two  = 1'b1;
			end
			ModeMap9: begin
				c.mask = RingHalf;
			end
			ModeMap10: begin
				c.mask = RingHalf;
				c.two  = 1'b1;
			end
			default: begin
			end
		endcase
		return c;
	endfunction

	// pixel value from held bits, name and mode
	function automatic logic [ValueW-1:0] decode_pixel(
		input logic [BitsW-1:0] bits,
		input logic [ByteW-1:0] name,
		input logic [ModeW-1:0] mode,
		input logic [CtrlW-1:0] ctrl
	);
		logic [BitsW-1:0]  v;
		logic              inv;
		logic [ValueW-1:0] r;
		v   = bits;
		inv = name[ByteW-1];
		if ((mode == ModeChar2 || mode == ModeChar3) && inv) begin
			if (ctrl[CtrlBlankInv]) v = '0;
			if (ctrl[CtrlInvert]) v = v ^ 2'b11;
		end
		r = {1'b0, v};
		if ((mode == ModeChar4 || mode == ModeChar5) && v == 2'b11 && inv) begin
			r = 3'd4;
		end else if (mode == ModeChar6 || mode == ModeChar7) begin
			r = (v != '0) ? ({1'b0, name[ByteW-1:ByteW-2]} + 3'd1) : 3'd0;
		end
		return r;
	endfunction

endpackage

FILE: sv/gqsr_slot_mem.sv
// ----------------------------------------------------------------------------
// gqsr_slot_mem: delay queue slot storage
// Byte, name and line index of each queue slot in synchronous memories with
// a registered read, forwarding the write of the previous cycle.
// ----------------------------------------------------------------------------
module gqsr_slot_mem import gqsr_pkg::*; #(
	parameter int SLOTS = QueueSlots,
	localparam int AW = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  slot_wr_t      wr,
	output slot_rd_t      rd
);

	logic [ByteW-1:0]  data_mem  [SLOTS];
	logic [ByteW-1:0]  name_mem  [SLOTS];
	logic [PhaseW-1:0] phase_mem [SLOTS];

	slot_rd_t      rd_q;
	logic [AW-1:0] rd_addr_q;
	slot_wr_t      fwd_q;
	logic [AW-1:0] fwd_addr_q;
	logic          fwd_v_q;
	logic          hit;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.data_we) data_mem[wr_addr] <= wr.data;
			if (wr.name_we) name_mem[wr_addr] <= wr.name;
			if (wr.phase_we) phase_mem[wr_addr] <= wr.phase;
			rd_q.data  <= data_mem[rd_addr];
			rd_q.name  <= name_mem[rd_addr];
			rd_q.phase <= phase_mem[rd_addr];
			rd_addr_q  <= rd_addr;
			fwd_q      <= wr;
			fwd_addr_q <= wr_addr;
		end
	end

	// last write is pending for the read just issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (en) begin
			fwd_v_q <= wr.data_we | wr.name_we | wr.phase_we;
		end
	end

	// forward same-slot write of the previous cycle
	assign hit = fwd_v_q && (fwd_addr_q == rd_addr_q);

	always_comb begin
		rd = rd_q;
		if (hit && fwd_q.data_we) rd.data = fwd_q.data;
		if (hit && fwd_q.name_we) rd.name = fwd_q.name;
		if (hit && fwd_q.phase_we) rd.phase = fwd_q.phase;
	end

endmodule

FILE: sv/gqsr_line_mem.sv
// ----------------------------------------------------------------------------
// gqsr_line_mem: line buffer store
// Synchronous line buffer memory with per-entry fill bits; unwritten entries
// read as zero and indexes beyond the store read as all ones.
// ----------------------------------------------------------------------------
module gqsr_line_mem import gqsr_pkg::*; #(
	parameter int LINE_BYTES = LineBytes,
	localparam int AW = $clog2(LINE_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              we,
	input  logic [PhaseW-1:0] addr,
	input  logic [ByteW-1:0]  wdata,
	output logic [ByteW-1:0]  rd_byte
);

	logic [ByteW-1:0]      line_mem [LINE_BYTES];
	logic [LINE_BYTES-1:0] filled_q;
	logic [ByteW-1:0]      rd_q;
	logic                  hit_q;
	logic                  miss_q;
	logic                  in_range;
	logic [AW-1:0]         idx;

	// index check
	assign in_range = (32'(addr) < LINE_BYTES);
	assign idx      = in_range ? AW'(addr) : '0;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we && in_range) line_mem[idx] <= wdata;
			rd_q <= line_mem[idx];
		end
	end

	// fill bits and read qualifiers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			hit_q    <= 1'b0;
			miss_q   <= 1'b0;
		end else if (en) begin
			if (we && in_range) filled_q[idx] <= 1'b1;
			hit_q  <= in_range && filled_q[idx];
			miss_q <= !in_range;
		end
	end

	assign rd_byte = miss_q ? LineMissByte : (hit_q ? rd_q : '0);

endmodule

FILE: sv/gqsr_shifter.sv
// ----------------------------------------------------------------------------
// gqsr_shifter: graphics shift register and clock ring
// Loads popped bytes, runs the four-phase ring with its per-mode mask, shifts
// out one or two bits and decodes the playfield value.
// ----------------------------------------------------------------------------
module gqsr_shifter import gqsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tick_op_t         op,
	input  logic [ByteW-1:0] line_byte,
	input  logic [CtrlW-1:0] char_control,
	output pixel_t           pix
);

	logic [RingW-1:0] ring_q, ring_n;
	logic [ByteW-1:0] shreg_q, shreg_n;
	logic [ByteW-1:0] name_q, name_n;
	logic [BitsW-1:0] bits_q, bits_n;
	shift_cfg_t       cfg;
	logic [ByteW-1:0] pop_byte;

	// next state of one tick
	always_comb begin
		ring_n   = ring_q;
		shreg_n  = shreg_q;
		name_n   = name_q;
		bits_n   = bits_q;
		cfg      = mode_shift_cfg(op.mode);
		pop_byte = op.data | (op.from_line ? line_byte : '0);
		if (op.early) begin
			ring_n  = '0;
			shreg_n = '0;
			bits_n  = '0;
		end else if (op.load) begin
			shreg_n   = shreg_n | pop_byte;
			name_n    = op.name;
			ring_n[0] = 1'b1;
		end
		if ((ring_n & cfg.mask) != '0) begin
			if (cfg.two) begin
				bits_n  = shreg_n[ByteW-1:ByteW-2];
				shreg_n = {shreg_n[ByteW-3:0], 2'b00};
			end else begin
				bits_n  = {1'b0, shreg_n[ByteW-1]};
				shreg_n = {shreg_n[ByteW-2:0], 1'b0};
			end
		end
		ring_n = {ring_n[RingW-2:0], ring_n[RingW-1]};
	end

	// shift state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q  <= '0;
			shreg_q <= '0;
			name_q  <= '0;
			bits_q  <= '0;
		end else if (en && op.fire) begin
			ring_q  <= ring_n;
			shreg_q <= shreg_n;
			name_q  <= name_n;
			bits_q  <= bits_n;
		end
	end

	// result reflects the state after this transaction
	always_comb begin
		pix.bits  = op.fire ? bits_n : bits_q;
		pix.name  = op.fire ? name_n : name_q;
		pix.value = decode_pixel(pix.bits, pix.name, op.mode, char_control);
	end

endmodule

FILE: sv/graphics_queue_shift_ring_core.sv
// ----------------------------------------------------------------------------
// graphics_queue_shift_ring_core: playfield delay queue and shift back end
// Pipeline: slot memory read, line memory read, shift update in three stages,
// slot writes forwarded to the next read; one transaction per cycle while the
// result stream does not stall the pipeline.
// Reset: async, clears queue masks, head, shift state, line fill bits, no sweep.
// ----------------------------------------------------------------------------
module graphics_queue_shift_ring_core import gqsr_pkg::*; #(
	parameter int QUEUE_SLOTS = QueueSlots,
	parameter int LINE_BYTES  = LineBytes
) (
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// mode[3:0], early_cycle[4], data_byte[12:5], char_name[20:13],
	// delay[24:21], phase[30:25], zero[31]
	input  logic [31:0]      s_axis_tdata,
	// func[1:0]
	input  logic [1:0]       s_axis_tuser,
	// result stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// pixel_bits[1:0], pixel_value[4:2], current_name[12:5], zero[15:13]
	output logic [15:0]      m_axis_tdata,
	// char_control write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CtrlW-1:0] cfg_data
);

	localparam int SLOT_AW = $clog2(QUEUE_SLOTS);

	// input fields
	func_t             in_func;
	logic [ModeW-1:0]  in_mode;
	logic              in_early;
	logic [ByteW-1:0]  in_data;
	logic [ByteW-1:0]  in_name;
	logic [DelayW-1:0] in_delay;
	logic [PhaseW-1:0] in_phase;

	logic              en;
	logic              acc;
	logic [CtrlW-1:0]  char_control_q;

	// queue control
	logic [SLOT_AW-1:0]     head_q, head_d;
	logic [QUEUE_SLOTS-1:0] valid_q, valid_d;
	logic [QUEUE_SLOTS-1:0] fl_q, fl_d;
	logic [SLOT_AW-1:0]     slot_addr;

	// stage 1
	logic               v_s1;
	func_t              func_s1;
	logic [ModeW-1:0]   mode_s1;
	logic               early_s1;
	logic [ByteW-1:0]   data_s1;
	logic [ByteW-1:0]   name_s1;
	logic [PhaseW-1:0]  phase_s1;
	logic [SLOT_AW-1:0] addr_s1;
	logic               svalid_s1;
	logic               sfl_s1;
	slot_wr_t           slot_wr;
	slot_rd_t           slot_rd;
	logic               line_we;
	logic [PhaseW-1:0]  line_addr;
	logic               tick_s1;

	// stage 2
	logic               v_s2;
	tick_op_t           op_s2;
	tick_op_t           op_in;
	logic [ByteW-1:0]   line_byte;
	pixel_t             pix;

	// unpack input transaction
	assign in_func  = func_t'(s_axis_tuser);
	assign in_mode  = s_axis_tdata[3:0];
	assign in_early = s_axis_tdata[4];
	assign in_data  = s_axis_tdata[12:5];
	assign in_name  = s_axis_tdata[20:13];
	assign in_delay = s_axis_tdata[24:21];
	assign in_phase = s_axis_tdata[30:25];

	// whole pipeline moves when the output register is free or drained
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_control_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			char_control_q <= cfg_data;
		end
	end

	// slot picked by this transaction
	assign slot_addr = (in_func == FUNC_TICK) ? head_q : (head_q + SLOT_AW'(in_delay));

	// slot masks and head, in transaction order
	always_comb begin
		valid_d = valid_q;
		fl_d    = fl_q;
		head_d  = head_q;
		case (in_func)
			FUNC_TICK: begin
				if (in_early) begin
					valid_d = '0;
					fl_d    = '0;
				end else begin
					valid_d[slot_addr] = 1'b0;
					fl_d[slot_addr]    = 1'b0;
				end
				head_d = head_q + SLOT_AW'(1);
			end
			FUNC_SCHED_GFX: begin
				valid_d[slot_addr] = 1'b1;
			end
			FUNC_SCHED_LINE: begin
				valid_d[slot_addr] = 1'b1;
				fl_d[slot_addr]    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			valid_q <= '0;
			fl_q    <= '0;
		end else if (acc) begin
			head_q  <= head_d;
			valid_q <= valid_d;
			fl_q    <= fl_d;
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1   <= in_func;
			mode_s1   <= in_mode;
			early_s1  <= in_early;
			data_s1   <= in_data;
			name_s1   <= in_name;
			phase_s1  <= in_phase;
			addr_s1   <= slot_addr;
			svalid_s1 <= valid_q[slot_addr];
			sfl_s1    <= fl_q[slot_addr];
		end
	end

	// slot storage
	gqsr_slot_mem #(
		.SLOTS (QUEUE_SLOTS)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rd_addr (slot_addr),
		.wr_addr (addr_s1),
		.wr      (slot_wr),
		.rd      (slot_rd)
	);

	// stage 1: slot write back, an empty slot holds a zero byte
	always_comb begin
		slot_wr.data_we  = v_s1 && (func_s1 == FUNC_SCHED_GFX || func_s1 == FUNC_SCHED_LINE);
		slot_wr.name_we  = slot_wr.data_we;
		slot_wr.phase_we = v_s1 && (func_s1 == FUNC_SCHED_LINE);
		slot_wr.data     = (svalid_s1 ? slot_rd.data : '0)
			| ((func_s1 == FUNC_SCHED_GFX) ? data_s1 : '0);
		slot_wr.name     = (func_s1 == FUNC_SCHED_GFX) ? name_s1 : '0;
		slot_wr.phase    = phase_s1;
	end

	// stage 1: line buffer access
	assign tick_s1   = (func_s1 == FUNC_TICK);
	assign line_we   = v_s1 && (func_s1 == FUNC_LINE_WR);
	assign line_addr = tick_s1 ? slot_rd.phase : phase_s1;

	gqsr_line_mem #(
		.LINE_BYTES (LINE_BYTES)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.we      (line_we),
		.addr    (line_addr),
		.wdata   (data_s1),
		.rd_byte (line_byte)
	);

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2.fire      <= tick_s1;
			op_s2.early     <= early_s1;
			op_s2.load      <= svalid_s1 && !early_s1;
			op_s2.from_line <= sfl_s1;
			op_s2.mode      <= mode_s1;
			op_s2.data      <= slot_rd.data;
			op_s2.name      <= slot_rd.name;
		end
	end

	// stage 2: shift and decode
	always_comb begin
		op_in      = op_s2;
		op_in.fire = v_s2 && op_s2.fire;
	end

	gqsr_shifter u_shifter (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.op           (op_in),
		.line_byte    (line_byte),
		.char_control (char_control_q),
		.pix          (pix)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {3'b000, pix};
		end
	end

`ifndef SYNTHESIS
	// a line reference always belongs to a pending slot
	a_line_in_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fl_q & ~valid_q) == '0)
		else $error("line flag set on empty slot");

	// an early tick empties the queue
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_func == FUNC_TICK && in_early) |=> (valid_q == '0 && fl_q == '0))
		else $error("queue not flushed by early tick");

	// every tick advances the head by one slot
	a_head_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_func == FUNC_TICK) |=> (head_q == $past(head_q) + SLOT_AW'(1)))
		else $error("queue head did not advance on tick");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: playfield delay queue and shift back end
// Drives directed and random command streams into the core (line buffer
// writes, graphics and line-buffer scheduling, ticks in every display mode,
// early-cycle flushes), predicts each pixel result with a local model of the
// slot queue, clock ring and mode decode, and checks every result in order.
// Both stream sides idle at random; char_control changes between phases.
// ----------------------------------------------------------------------------
module testbench;
	import gqsr_pkg::*;

	localparam int ClkPeriod     = 20;
	localparam int TimeoutCycles = 100_000;
	localparam int PhaseItems    = 150;
	localparam int RandomPhases  = 8;
	localparam int HoldCycles    = 400;
	localparam int SettleCycles  = 4;
	// char_control per phase, phase 0 in the lowest bits
	localparam logic [3*(RandomPhases+1)-1:0] CtrlPlan =
		{3'd7, 3'd5, 3'd6, 3'd3, 3'd4, 3'd1, 3'd7, 3'd0, 3'd2};

	typedef struct packed {
		func_t             func;
		logic [ModeW-1:0]  mode;
		logic              early;
		logic [ByteW-1:0]  data;
		logic [ByteW-1:0]  name;
		logic [DelayW-1:0] delay;
		logic [PhaseW-1:0] phase;
	} gfx_cmd_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_SPARSE
	} ready_style_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [31:0]      s_axis_tdata = '0;
	logic [1:0]       s_axis_tuser = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [15:0]      m_axis_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CtrlW-1:0] cfg_data = '0;

	gfx_cmd_t cmd_backlog[$];
	pixel_t   pending_pixels[$];
	int       mismatch_count = 0;

	// local copy of the playfield state
	logic [ByteW-1:0]      pf_slot_byte [QueueSlots];
	logic [ByteW-1:0]      pf_slot_name [QueueSlots];
	logic [PhaseW-1:0]     pf_slot_ix   [QueueSlots];
	logic [QueueSlots-1:0] pf_armed;
	logic [QueueSlots-1:0] pf_line_ref;
	logic [3:0]            pf_head;
	logic [ByteW-1:0]      pf_line_buf  [LineBytes];
	logic [RingW-1:0]      pf_ring;
	logic [ByteW-1:0]      pf_shreg;
	logic [ByteW-1:0]      pf_name;
	logic [BitsW-1:0]      pf_bits;
	logic [CtrlW-1:0]      pf_ctrl;

	graphics_queue_shift_ring_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#(ClkPeriod / 2) clk = 1'b1;
		#(ClkPeriod / 2) clk = 1'b0;
	end

	// apply one command to the local state and return the pixel it reports
	function automatic pixel_t advance_playfield(input gfx_cmd_t c);
		logic [3:0]        slot;
		logic [RingW-1:0]  sh_mask;
		logic              sh_two;
		logic [BitsW-1:0]  v;
		logic              inv;
		pixel_t            px;
		slot = pf_head + c.delay;
		case (c.func)
			FUNC_TICK: begin
				slot = pf_head;
				if (c.early) begin
					// early machine cycle: flush queue and shifter, names stay
					pf_ring     = '0;
					pf_shreg    = '0;
					pf_bits     = '0;
					pf_armed    = '0;
					pf_line_ref = '0;
					for (int i = 0; i < QueueSlots; i++) pf_slot_byte[i] = '0;
				end else if (pf_armed[slot]) begin
					// pop head slot into the shifter
					if (pf_line_ref[slot]) begin
						pf_slot_byte[slot] |= (pf_slot_ix[slot] < LineBytes) ?
							pf_line_buf[pf_slot_ix[slot]] : LineMissByte;
					end
					pf_shreg           |= pf_slot_byte[slot];
					pf_name             = pf_slot_name[slot];
					pf_ring[0]          = 1'b1;
					pf_armed[slot]      = 1'b0;
					pf_line_ref[slot]   = 1'b0;
					pf_slot_byte[slot]  = '0;
				end
				// ring mask and shift width per mode
				sh_mask = RingAll;
				sh_two  = 1'b0;
				case (c.mode)
					ModeChar2, ModeChar3, ModeChar4, ModeChar5,
					ModeMap13, ModeMap14, ModeMap15: sh_two = 1'b1;
					ModeMap8: begin
						sh_mask = RingOne;
						sh_two  = 1'b1;
					end
					ModeMap9: sh_mask = RingHalf;
					ModeMap10: begin
						sh_mask = RingHalf;
						sh_two  = 1'b1;
					end
					default: begin
					end
				endcase
				if ((pf_ring & sh_mask) != '0) begin
					if (sh_two) begin
						pf_bits  = pf_shreg[7:6];
						pf_shreg = pf_shreg << 2;
					end else begin
						pf_bits  = {1'b0, pf_shreg[7]};
						pf_shreg = pf_shreg << 1;
					end
				end
				pf_ring = {pf_ring[RingW-2:0], pf_ring[RingW-1]};
				pf_head = pf_head + 4'd1;
			end
			FUNC_SCHED_GFX: begin
				pf_slot_byte[slot] |= c.data;
				pf_slot_name[slot]  = c.name;
				pf_armed[slot]      = 1'b1;
			end
			FUNC_SCHED_LINE: begin
				pf_line_ref[slot]  = 1'b1;
				pf_slot_ix[slot]   = c.phase;
				pf_slot_name[slot] = '0;
				pf_armed[slot]     = 1'b1;
			end
			default: begin
				if (c.phase < LineBytes) pf_line_buf[c.phase] = c.data;
			end
		endcase
		// mode decode of the held bits
		v   = pf_bits;
		inv = pf_name[ByteW-1];
		if ((c.mode == ModeChar2 || c.mode == ModeChar3) && inv) begin
			if (pf_ctrl[CtrlBlankInv]) v = '0;
			if (pf_ctrl[CtrlInvert]) v = ~v;
		end
		px.bits = pf_bits;
		px.name = pf_name;
		if ((c.mode == ModeChar4 || c.mode == ModeChar5) && v == 2'b11 && inv) begin
			px.value = 3'd4;
		end else if (c.mode == ModeChar6 || c.mode == ModeChar7) begin
			px.value = (v != '0) ? ({1'b0, pf_name[7:6]} + 3'd1) : 3'd0;
		end else begin
			px.value = {1'b0, v};
		end
		return px;
	endfunction

	function automatic gfx_cmd_t random_cmd();
		gfx_cmd_t c;
		c.func  = func_t'($urandom_range(0, 3));
		c.mode  = ModeW'($urandom_range(0, 15));
		c.early = 1'($urandom_range(0, 1));
		c.data  = ByteW'($urandom_range(0, 255));
		c.name  = ByteW'($urandom_range(0, 255));
		c.delay = DelayW'($urandom_range(0, 15));
		c.phase = PhaseW'($urandom_range(0, 63));
		return c;
	endfunction

	task automatic push_cmd(input func_t f, input logic [ModeW-1:0] m, input logic e,
			input logic [ByteW-1:0] d, input logic [ByteW-1:0] n,
			input logic [DelayW-1:0] dl, input logic [PhaseW-1:0] ph);
		gfx_cmd_t c;
		c = '{func: f, mode: m, early: e, data: d, name: n, delay: dl, phase: ph};
		cmd_backlog.push_back(c);
	endtask

	// one display line: flush cycles, then ticks with scheduling in between
	task automatic queue_scanline(inout int added);
		gfx_cmd_t         c;
		logic [ModeW-1:0] line_mode;
		int               flush_n;
		int               span;
		int               extra;
		line_mode = ModeW'($urandom_range(0, 15));
		flush_n   = $urandom_range(0, 3);
		span      = $urandom_range(8, 40);
		for (int k = 0; k < flush_n; k++) begin
			c       = random_cmd();
			c.func  = FUNC_TICK;
			c.mode  = line_mode;
			c.early = 1'b1;
			cmd_backlog.push_back(c);
			added++;
		end
		for (int k = 0; k < span; k++) begin
			extra = $urandom_range(0, 2);
			for (int j = 0; j < extra; j++) begin
				c       = random_cmd();
				c.mode  = line_mode;
				c.early = 1'b0;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						c.func = FUNC_SCHED_GFX;
						if ($urandom_range(0, 3) != 0) c.delay = DelayW'($urandom_range(0, 4));
					end
					6, 7: begin
						c.func = FUNC_SCHED_LINE;
						if ($urandom_range(0, 5) != 0) begin
							c.phase = PhaseW'($urandom_range(0, LineBytes - 1));
						end
					end
					default: begin
						c.func = FUNC_LINE_WR;
						if ($urandom_range(0, 5) != 0) begin
							c.phase = PhaseW'($urandom_range(0, LineBytes - 1));
						end
					end
				endcase
				cmd_backlog.push_back(c);
				added++;
			end
			c       = random_cmd();
			c.func  = FUNC_TICK;
			c.mode  = line_mode;
			c.early = 1'b0;
			// occasional stray command breaks the line
			if ($urandom_range(0, 11) == 0) c = random_cmd();
			cmd_backlog.push_back(c);
			added++;
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (cmd_backlog.size() != 0 || pending_pixels.size() != 0);
	endtask

	task automatic write_char_control(input logic [CtrlW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		pf_ctrl = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
		end
	endtask

	// input driver: bursts of commands with random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		logic nxt_valid;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_pixels.push_back(advance_playfield(cmd_backlog.pop_front()));
				if (burst_left > 0) burst_left--;
			end
			if (burst_left == 0) begin
				gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				burst_left = $urandom_range(1, 48);
			end
			if (gap_left > 0) begin
				gap_left--;
				nxt_valid = 1'b0;
			end else begin
				nxt_valid = (cmd_backlog.size() != 0);
			end
			s_axis_tvalid <= nxt_valid;
			if (nxt_valid) begin
				s_axis_tuser <= cmd_backlog[0].func;
				s_axis_tdata <= {1'b0, cmd_backlog[0].phase, cmd_backlog[0].delay,
					cmd_backlog[0].name, cmd_backlog[0].data, cmd_backlog[0].early,
					cmd_backlog[0].mode};
			end
		end
	end

	// output ready: styles in random segments plus two long hold-offs
	ready_style_t rdy_style  = READY_ALWAYS;
	int           seg_left   = 0;
	int           hold_left  = 0;
	int           hold_index = 0;
	int           rx_count   = 0;

	always @(posedge clk or negedge arst_n) begin : result_ready
		logic nxt_ready;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) rx_count++;
			if (hold_left > 0) begin
				hold_left--;
				nxt_ready = 1'b0;
			end else if ((hold_index == 0 && rx_count >= 450) ||
					(hold_index == 1 && rx_count >= 1100)) begin
				hold_index++;
				hold_left = HoldCycles;
				nxt_ready = 1'b0;
			end else begin
				if (seg_left == 0) begin
					rdy_style = ready_style_t'($urandom_range(0, 2));
					seg_left  = $urandom_range(16, 128);
				end
				seg_left--;
				case (rdy_style)
					READY_ALWAYS: nxt_ready = 1'b1;
					READY_RANDOM: nxt_ready = 1'($urandom_range(0, 1));
					default:      nxt_ready = ($urandom_range(0, 3) == 0);
				endcase
			end
			m_axis_tready <= nxt_ready;
		end
	end

	// result checker
	always @(posedge clk) begin : pixel_check
		pixel_t got;
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = pixel_t'(m_axis_tdata[12:0]);
			if (pending_pixels.size() == 0) begin
				flag_mismatch("unexpected result", 0, 32'(got));
			end else begin
				want = pending_pixels.pop_front();
				if (got.bits != want.bits) begin
					flag_mismatch("pixel_bits", 32'(want.bits), 32'(got.bits));
				end
				if (got.value != want.value) begin
					flag_mismatch("pixel_value", 32'(want.value), 32'(got.value));
				end
				if (got.name != want.name) begin
					flag_mismatch("current_name", 32'(want.name), 32'(got.name));
				end
			end
		end
	end

	initial begin
		#(TimeoutCycles * ClkPeriod);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int added;
		for (int i = 0; i < QueueSlots; i++) begin
			pf_slot_byte[i] = '0;
			pf_slot_name[i] = '0;
			pf_slot_ix[i]   = '0;
		end
		for (int i = 0; i < LineBytes; i++) pf_line_buf[i] = '0;
		pf_armed    = '0;
		pf_line_ref = '0;
		pf_head     = '0;
		pf_ring     = '0;
		pf_shreg    = '0;
		pf_name     = '0;
		pf_bits     = '0;
		pf_ctrl     = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: line buffer ends, out-of-range index, merged slot, all modes
		write_char_control(CtrlPlan[2:0]);
		@(negedge clk);
		push_cmd(FUNC_LINE_WR,    4'd0, 1'b0, 8'hff, 8'h00, 4'd0,  6'd0);
		push_cmd(FUNC_LINE_WR,    4'd0, 1'b0, 8'ha5, 8'h00, 4'd0,  6'd47);
		push_cmd(FUNC_LINE_WR,    4'd0, 1'b0, 8'h3c, 8'h00, 4'd0,  6'd63);
		push_cmd(FUNC_SCHED_GFX,  4'd2, 1'b0, 8'hff, 8'h80, 4'd0,  6'd0);
		push_cmd(FUNC_SCHED_GFX,  4'd2, 1'b0, 8'h0f, 8'hc0, 4'd1,  6'd0);
		push_cmd(FUNC_SCHED_GFX,  4'd2, 1'b0, 8'hf0, 8'h41, 4'd1,  6'd0);
		push_cmd(FUNC_SCHED_LINE, 4'd2, 1'b0, 8'h00, 8'hff, 4'd2,  6'd47);
		push_cmd(FUNC_SCHED_LINE, 4'd2, 1'b0, 8'h00, 8'hff, 4'd3,  6'd63);
		push_cmd(FUNC_SCHED_GFX,  4'd2, 1'b0, 8'h81, 8'hff, 4'd15, 6'd0);
		for (int m = 0; m < 16; m++) begin
			push_cmd(FUNC_TICK, ModeW'(m), 1'b0, 8'h00, 8'h00, 4'd0, 6'd0);
		end
		push_cmd(FUNC_SCHED_GFX,  4'd6, 1'b0, 8'hff, 8'hc0, 4'd0,  6'd0);
		push_cmd(FUNC_TICK,       4'd6, 1'b1, 8'h00, 8'h00, 4'd0,  6'd0);
		push_cmd(FUNC_TICK,       4'd6, 1'b0, 8'h00, 8'h00, 4'd0,  6'd0);
		wait_idle();
		repeat (SettleCycles) @(posedge clk);

		for (int p = 1; p <= RandomPhases; p++) begin
			write_char_control(CtrlPlan[3*p +: 3]);
			@(negedge clk);
			added = 0;
			while (added < PhaseItems) queue_scanline(added);
			wait_idle();
			repeat (SettleCycles) @(posedge clk);
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: graphics_queue_shift_ring_core.f
sv/gqsr_pkg.sv
sv/gqsr_slot_mem.sv
sv/gqsr_line_mem.sv
sv/gqsr_shifter.sv
sv/graphics_queue_shift_ring_core.sv
dv/testbench.sv
